[rtl/cicdm_pkg.sv]
// Shared constants and codes for the cloud-in-cell density mesh.
`timescale 1ns / 1ps

package cicdm_pkg;

    // Field widths fixed by the interface
    localparam int POS_W     = 32;
    localparam int SCALE_W   = 24;
    localparam int CNT_W     = 5;
    localparam int WEIGHT_W  = 32;
    localparam int TOTAL_W   = 40;
    localparam int ACT_W     = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 32;

    // Position arithmetic: signed difference times zero-extended scale
    localparam int DIFF_W    = POS_W + 1;
    localparam int SCALE_S_W = SCALE_W + 1;
    localparam int PROD_W    = DIFF_W + SCALE_S_W;

    // Linear cell index before the store bound check
    localparam int LIN_W     = 17;

    // Sequencing counts
    localparam logic [1:0] AXIS_LAST = 2'd3;
    localparam logic [2:0] VTX_LAST  = 3'd7;

    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = {WEIGHT_W{1'b1}};
    localparam logic [TOTAL_W-1:0]  TOTAL_MAX  = {TOTAL_W{1'b1}};

    // Action codes
    localparam logic [ACT_W-1:0] ACT_DEPOSIT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_SAMPLE  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CLEAR   = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_SCALE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CELLS_X    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CELLS_Y    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CELLS_Z    = 3'd6;

endpackage

[rtl/cloud_in_cell_density_mesh.sv]
// Cloud-in-cell mass deposit mesh with column sampling over a weight memory.
// Deposit: the next word is accepted only once the deposit is done (3 axis splits on one shared
//   multiplier, 8 vertex read-modify-writes through a 3-stage memory pipeline, drain).
// Sample: axis splits, a cell read, then an accumulate; the last sample registers the column word.
// Clear: all MESH_CELLS entries, one memory entry zeroed per cycle.
// After reset the block runs the same clearing pass with in_ready low.
`timescale 1ns / 1ps

module cloud_in_cell_density_mesh
    import cicdm_pkg::*;
#(
    parameter int MESH_CELLS = 4096,
    parameter int FRAC_BITS  = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    // configuration
    input  logic                    cfg_write,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]        cfg_data,
    // input channel
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [ACT_W-1:0]        action,
    input  logic signed [POS_W-1:0] pos_x,
    input  logic signed [POS_W-1:0] pos_y,
    input  logic signed [POS_W-1:0] pos_z,
    input  logic                    last_sample,
    // output channel
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [TOTAL_W-1:0]      column_density
);

    localparam int AW     = $clog2(MESH_CELLS);
    localparam int CELL_W = PROD_W - 2 * FRAC_BITS;
    localparam int WT_W   = FRAC_BITS + 1;
    localparam int WSQ_W  = 2 * WT_W;
    localparam logic [WT_W-1:0] W_ONE = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(64'd1 << FRAC_BITS);

    localparam logic [2:0] ST_CLR   = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_SPLIT = 3'd2;
    localparam logic [2:0] ST_VTX   = 3'd3;
    localparam logic [2:0] ST_DRAIN = 3'd4;
    localparam logic [2:0] ST_SRD   = 3'd5;
    localparam logic [2:0] ST_SACC  = 3'd6;

    // configuration registers
    logic signed [POS_W-1:0] origin_x_reg, origin_y_reg, origin_z_reg;
    logic [SCALE_W-1:0]      cell_scale_reg;
    logic [CNT_W-1:0]        cells_x_reg, cells_y_reg, cells_z_reg;

    // control
    logic [2:0]    state_reg, state_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    logic          out_valid_reg, out_valid_next;
    logic [TOTAL_W-1:0] column_total_reg, column_total_next;
    logic          prev_valid_reg, prev_valid_next;
    logic [AW-1:0] prev_cell_reg, prev_cell_next;
    logic          s1_vld_reg;
    logic          s2_we_reg;

    // latched item
    logic                    deposit_reg;
    logic                    last_reg;
    logic signed [POS_W-1:0] pos_x_reg, pos_y_reg, pos_z_reg;

    // axis split
    logic signed [DIFF_W-1:0]    diff;
    logic signed [SCALE_S_W-1:0] scale_s;
    logic signed [PROD_W-1:0]    prod;
    logic signed [PROD_W-1:0]    prod_reg;
    logic [CELL_W-1:0]           cell_id;
    logic [CELL_W:0]             cell_p1;
    logic [1:0]                  dec_axis;
    logic [FRAC_BITS-1:0]        f_reg  [3];
    logic [CNT_W-1:0]            c0_reg [3];
    logic [CNT_W-1:0]            c1_reg [3];
    logic                        ok0_reg[3];
    logic                        ok1_reg[3];

    // vertex select and linear index
    logic [2:0]        sel;
    logic [CNT_W-1:0]  ix, iy, iz;
    logic              okx, oky, okz;
    logic [2*CNT_W-1:0] m1;
    logic [2*CNT_W:0]   t1;
    logic [3*CNT_W:0]   m2;
    logic [LIN_W-1:0]   lin;
    logic               lin_ok;
    logic [AW-1:0]      rd_addr;

    // weights
    logic [WT_W-1:0]  wx, wy, wz;
    logic [WSQ_W-1:0] mul_xy, mul_xyz;

    // memory pipeline
    logic [WEIGHT_W-1:0] vertex_weight_mem [MESH_CELLS];
    logic [WEIGHT_W-1:0] rd_data_reg;
    logic                s1_ok_reg;
    logic [AW-1:0]       s1_idx_reg;
    logic [WT_W-1:0]     s1_wxy_reg, s1_wz_reg;
    logic [AW-1:0]       s2_idx_reg;
    logic [WT_W-1:0]     s2_wt_reg;
    logic [WEIGHT_W-1:0] s2_old_reg;
    logic [WEIGHT_W:0]   wsum;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [WEIGHT_W-1:0] mem_wdata;

    // sample
    logic                samp_ok_reg;
    logic [AW-1:0]       samp_idx_reg;
    logic                hit;
    logic [TOTAL_W:0]    tsum;
    logic [TOTAL_W-1:0]  tot_upd;
    logic                out_block;
    logic [TOTAL_W-1:0]  column_density_reg;

    assign in_ready       = (state_reg == ST_IDLE);
    assign out_valid      = out_valid_reg;
    assign column_density = column_density_reg;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg   <= '0;
            origin_y_reg   <= '0;
            origin_z_reg   <= '0;
            cell_scale_reg <= SCALE_RESET;
            cells_x_reg    <= CNT_W'(16);
            cells_y_reg    <= CNT_W'(16);
            cells_z_reg    <= CNT_W'(16);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_ORIGIN_X:   origin_x_reg   <= cfg_data;
                REG_ORIGIN_Y:   origin_y_reg   <= cfg_data;
                REG_ORIGIN_Z:   origin_z_reg   <= cfg_data;
                REG_CELL_SCALE: cell_scale_reg <= cfg_data[SCALE_W-1:0];
                REG_CELLS_X:    cells_x_reg    <= cfg_data[CNT_W-1:0];
                REG_CELLS_Y:    cells_y_reg    <= cfg_data[CNT_W-1:0];
                REG_CELLS_Z:    cells_z_reg    <= cfg_data[CNT_W-1:0];
                default:        ;
            endcase
        end
    end

    // ---------------- axis split on one shared multiplier ----------------
    always_comb
    begin
        case (cnt_reg[1:0])
            2'd0:    diff = {pos_x_reg[POS_W-1], pos_x_reg} - {origin_x_reg[POS_W-1], origin_x_reg};
            2'd1:    diff = {pos_y_reg[POS_W-1], pos_y_reg} - {origin_y_reg[POS_W-1], origin_y_reg};
            default: diff = {pos_z_reg[POS_W-1], pos_z_reg} - {origin_z_reg[POS_W-1], origin_z_reg};
        endcase
        scale_s = {1'b0, cell_scale_reg};
        prod    = diff * scale_s;
    end

    // floor shifts are plain bit drops in two's complement
    assign cell_id  = prod_reg[PROD_W-1:2*FRAC_BITS];
    assign cell_p1  = {cell_id[CELL_W-1], cell_id} + (CELL_W+1)'(1);
    assign dec_axis = cnt_reg[1:0] - 2'd1;

    function automatic logic [CNT_W-1:0] cells_sel(input logic [1:0] a);
        logic [CNT_W-1:0] r;
        case (a)
            2'd0:    r = cells_x_reg;
            2'd1:    r = cells_y_reg;
            default: r = cells_z_reg;
        endcase
        return r;
    endfunction

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SPLIT)
        begin
            prod_reg <= prod;
            if (cnt_reg[1:0] != 2'd0)
            begin
                f_reg[dec_axis]   <= prod_reg[2*FRAC_BITS-1:FRAC_BITS];
                c0_reg[dec_axis]  <= cell_id[CNT_W-1:0];
                c1_reg[dec_axis]  <= cell_p1[CNT_W-1:0];
                ok0_reg[dec_axis] <= (cell_id[CELL_W-1:CNT_W] == '0)
                                     && (cell_id[CNT_W-1:0] < cells_sel(dec_axis));
                ok1_reg[dec_axis] <= (cell_p1[CELL_W:CNT_W] == '0)
                                     && (cell_p1[CNT_W-1:0] < cells_sel(dec_axis));
            end
        end
    end

    // ---------------- vertex index and weights ----------------
    assign sel = (state_reg == ST_VTX) ? cnt_reg[2:0] : 3'd0;

    always_comb
    begin
        ix  = sel[2] ? c1_reg[0] : c0_reg[0];
        iy  = sel[1] ? c1_reg[1] : c0_reg[1];
        iz  = sel[0] ? c1_reg[2] : c0_reg[2];
        okx = sel[2] ? ok1_reg[0] : ok0_reg[0];
        oky = sel[1] ? ok1_reg[1] : ok0_reg[1];
        okz = sel[0] ? ok1_reg[2] : ok0_reg[2];
        m1  = ix * cells_y_reg;
        t1  = {1'b0, m1} + {{(CNT_W+1){1'b0}}, iy};
        m2  = t1 * cells_z_reg;
        lin = {1'b0, m2} + {{(LIN_W-CNT_W){1'b0}}, iz};
        lin_ok  = okx && oky && okz && (32'(lin) < 32'(MESH_CELLS));
        rd_addr = lin[AW-1:0];

        wx = sel[2] ? {1'b0, f_reg[0]} : W_ONE - {1'b0, f_reg[0]};
        wy = sel[1] ? {1'b0, f_reg[1]} : W_ONE - {1'b0, f_reg[1]};
        wz = sel[0] ? {1'b0, f_reg[2]} : W_ONE - {1'b0, f_reg[2]};
        mul_xy  = wx * wy;
        mul_xyz = s1_wxy_reg * s1_wz_reg;
    end

    // ---------------- weight memory ----------------
    assign wsum = {1'b0, s2_old_reg} + {{(WEIGHT_W+1-WT_W){1'b0}}, s2_wt_reg};

    always_comb
    begin
        if (state_reg == ST_CLR)
        begin
            mem_we    = 1'b1;
            mem_waddr = cnt_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = s2_we_reg;
            mem_waddr = s2_idx_reg;
            mem_wdata = wsum[WEIGHT_W] ? WEIGHT_MAX : wsum[WEIGHT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            vertex_weight_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= vertex_weight_mem[rd_addr];
    end

    // vertex pipeline: issue read, scale weight, add and write back
    always_ff @(posedge clk)
    begin
        s1_ok_reg  <= lin_ok;
        s1_idx_reg <= rd_addr;
        s1_wxy_reg <= mul_xy[2*FRAC_BITS:FRAC_BITS];
        s1_wz_reg  <= wz;
        s2_idx_reg <= s1_idx_reg;
        s2_wt_reg  <= mul_xyz[2*FRAC_BITS:FRAC_BITS];
        s2_old_reg <= rd_data_reg;
        if (state_reg == ST_SRD)
        begin
            samp_ok_reg  <= lin_ok;
            samp_idx_reg <= rd_addr;
        end
        if (in_valid && in_ready)
        begin
            deposit_reg <= (action == ACT_DEPOSIT);
            last_reg    <= last_sample;
            pos_x_reg   <= pos_x;
            pos_y_reg   <= pos_y;
            pos_z_reg   <= pos_z;
        end
    end

    // ---------------- sample accumulate ----------------
    assign hit       = samp_ok_reg && (!prev_valid_reg || (samp_idx_reg != prev_cell_reg));
    assign tsum      = {1'b0, column_total_reg} + {{(TOTAL_W+1-WEIGHT_W){1'b0}}, rd_data_reg};
    assign tot_upd   = hit ? (tsum[TOTAL_W] ? TOTAL_MAX : tsum[TOTAL_W-1:0]) : column_total_reg;
    assign out_block = out_valid_reg && !out_ready;

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SACC && last_reg && !out_block)
        begin
            column_density_reg <= tot_upd;
        end
    end

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        column_total_next = column_total_reg;
        prev_valid_next   = prev_valid_reg;
        prev_cell_next    = prev_cell_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        case (state_reg)
            ST_CLR:
            begin
                cnt_next = cnt_reg + AW'(1);
                if (cnt_reg == AW'(MESH_CELLS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                cnt_next = '0;
                if (in_valid)
                begin
                    case (action)
                        ACT_DEPOSIT: state_next = ST_SPLIT;
                        ACT_SAMPLE:  state_next = ST_SPLIT;
                        ACT_CLEAR:   state_next = ST_CLR;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SPLIT:
            begin
                cnt_next = cnt_reg + AW'(1);
                if (cnt_reg[1:0] == AXIS_LAST)
                begin
                    cnt_next   = '0;
                    state_next = deposit_reg ? ST_VTX : ST_SRD;
                end
            end
            ST_VTX:
            begin
                cnt_next = cnt_reg + AW'(1);
                if (cnt_reg[2:0] == VTX_LAST)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // the last write lands at this edge once stage one is empty
                if (!s1_vld_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SRD:
            begin
                state_next = ST_SACC;
            end
            ST_SACC:
            begin
                if (!(last_reg && out_block))
                begin
                    state_next        = ST_IDLE;
                    column_total_next = tot_upd;
                    if (hit)
                    begin
                        prev_valid_next = 1'b1;
                        prev_cell_next  = samp_idx_reg;
                    end
                    if (last_reg)
                    begin
                        out_valid_next    = 1'b1;
                        column_total_next = '0;
                        prev_valid_next   = 1'b0;
                        prev_cell_next    = '0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLR;
            cnt_reg          <= '0;
            out_valid_reg    <= 1'b0;
            column_total_reg <= '0;
            prev_valid_reg   <= 1'b0;
            prev_cell_reg    <= '0;
            s1_vld_reg       <= 1'b0;
            s2_we_reg        <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            out_valid_reg    <= out_valid_next;
            column_total_reg <= column_total_next;
            prev_valid_reg   <= prev_valid_next;
            prev_cell_reg    <= prev_cell_next;
            s1_vld_reg       <= (state_reg == ST_VTX);
            s2_we_reg        <= s1_vld_reg && s1_ok_reg;
        end
    end

    // ---------------- assertions ----------------
    a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (!s1_vld_reg && !s2_we_reg))
        else $error("word accepted while vertex pipeline busy");

    a_clear_no_update: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLR) |-> !s2_we_reg)
        else $error("vertex write during clearing pass");

    a_pipe_in_deposit: assert property (@(posedge clk) disable iff (!rst_n)
        s1_vld_reg |-> (state_reg == ST_VTX || state_reg == ST_DRAIN))
        else $error("vertex stage active outside deposit");

    a_column_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SACC && last_reg && !out_block)
        |=> (out_valid_reg && column_total_reg == '0 && !prev_valid_reg))
        else $error("column not emitted and restarted on last sample");

endmodule

[sim/tb_cloud_in_cell_density_mesh.sv]
// Self-checking testbench for the cloud-in-cell density mesh: deposits, column samples, clears.
`timescale 1ns / 1ps

module tb_cloud_in_cell_density_mesh;
    import cicdm_pkg::*;

    localparam int MESH_CELLS  = 4096;
    localparam int FRAC_BITS   = 16;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE      = 40;
    localparam int PHASE_WORDS = 165;
    localparam int RAND_PHASES = 8;
    localparam logic [ACT_W-1:0] ACT_RESERVED = 2'd3;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic [ACT_W-1:0]     action;
    logic [POS_W-1:0]     pos_x;
    logic [POS_W-1:0]     pos_y;
    logic [POS_W-1:0]     pos_z;
    logic                 last_sample;
    logic                 out_valid;
    logic                 out_ready;
    logic [TOTAL_W-1:0]   column_density;

    // mirror of the block's state and settings
    logic [WEIGHT_W-1:0]  mesh_weight [MESH_CELLS];
    longint unsigned      column_sum;
    bit                   have_cell;
    int                   counted_cell;
    logic [POS_W-1:0]     cfg_origin [3];
    int                   cfg_scale;
    int                   cfg_cells [3];
    logic [TOTAL_W-1:0]   expected_density [$];
    logic [TOTAL_W-1:0]   density_want;

    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;
    int errors          = 0;
    int results_checked = 0;
    int cycle_count     = 0;
    int n_words         = 0;
    int n_deposit       = 0;
    int n_sample        = 0;
    int n_clear         = 0;
    int n_ignored       = 0;

    cloud_in_cell_density_mesh #(
        .MESH_CELLS (MESH_CELLS),
        .FRAC_BITS  (FRAC_BITS)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .action         (action),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .pos_z          (pos_z),
        .last_sample    (last_sample),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .column_density (column_density)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: run exceeded %0d cycles, %0d results outstanding",
                 $time, CYCLE_LIMIT, expected_density.size());
        $display("cloud_in_cell_density_mesh test failed");
        $finish;
    end

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            results_checked++;
            if (expected_density.size() == 0)
            begin
                errors++;
                $display("%0t: column_density expected none, actual %h", $time, column_density);
            end
            else
            begin
                density_want = expected_density.pop_front();
                if (column_density !== density_want)
                begin
                    errors++;
                    $display("%0t: column_density expected %h, actual %h",
                             $time, density_want, column_density);
                end
            end
        end
    end

    // ---------------------------------------------------------------- prediction

    function automatic void locate_axis(input logic [POS_W-1:0] pos, input logic [POS_W-1:0] org,
                                        output longint cidx, output longint frac);
        longint offs;
        longint scaled;
        offs   = longint'($signed(pos)) - longint'($signed(org));
        scaled = (offs * longint'(cfg_scale)) >>> FRAC_BITS;
        cidx   = scaled >>> FRAC_BITS;
        frac   = scaled & ((longint'(1) <<< FRAC_BITS) - 1);
    endfunction

    function automatic bit cell_address(input longint ix, iy, iz, output int idx);
        longint lin;
        idx = 0;
        if (ix < 0 || iy < 0 || iz < 0)
            return 1'b0;
        if (ix >= cfg_cells[0] || iy >= cfg_cells[1] || iz >= cfg_cells[2])
            return 1'b0;
        lin = (ix * cfg_cells[1] + iy) * cfg_cells[2] + iz;
        if (lin >= MESH_CELLS)
            return 1'b0;
        idx = int'(lin);
        return 1'b1;
    endfunction

    function automatic void spread_particle(input logic [POS_W-1:0] px, py, pz);
        logic [POS_W-1:0] pos [3];
        longint           cidx [3];
        longint           frac [3];
        longint unsigned  share [3][2];
        longint unsigned  wt;
        longint unsigned  sum;
        int               idx;
        bit               hit;
        pos[0] = px;
        pos[1] = py;
        pos[2] = pz;
        for (int a = 0; a < 3; a++)
        begin
            locate_axis(pos[a], cfg_origin[a], cidx[a], frac[a]);
            share[a][0] = (64'd1 << FRAC_BITS) - frac[a];
            share[a][1] = frac[a];
        end
        for (int dx = 0; dx < 2; dx++)
            for (int dy = 0; dy < 2; dy++)
                for (int dz = 0; dz < 2; dz++)
                begin
                    hit = cell_address(cidx[0] + dx, cidx[1] + dy, cidx[2] + dz, idx);
                    if (hit)
                    begin
                        wt  = (share[0][dx] * share[1][dy]) >> FRAC_BITS;
                        wt  = (wt * share[2][dz]) >> FRAC_BITS;
                        sum = mesh_weight[idx] + wt;
                        mesh_weight[idx] = (sum > WEIGHT_MAX) ? WEIGHT_MAX : sum[WEIGHT_W-1:0];
                    end
                end
    endfunction

    function automatic void advance_mesh(input logic [ACT_W-1:0] act,
                                         input logic [POS_W-1:0] px, py, pz,
                                         input logic last);
        longint cx, cy, cz, fx, fy, fz;
        int     idx;
        bit     hit;
        case (act)
            ACT_DEPOSIT:
            begin
                n_deposit++;
                spread_particle(px, py, pz);
            end
            ACT_CLEAR:
            begin
                n_clear++;
                foreach (mesh_weight[i])
                    mesh_weight[i] = '0;
            end
            ACT_SAMPLE:
            begin
                n_sample++;
                locate_axis(px, cfg_origin[0], cx, fx);
                locate_axis(py, cfg_origin[1], cy, fy);
                locate_axis(pz, cfg_origin[2], cz, fz);
                hit = cell_address(cx, cy, cz, idx);
                // count a cell only when the skewer moves into a new one
                if (hit && (!have_cell || idx != counted_cell))
                begin
                    column_sum += mesh_weight[idx];
                    if (column_sum > TOTAL_MAX)
                        column_sum = TOTAL_MAX;
                    have_cell    = 1'b1;
                    counted_cell = idx;
                end
                if (last)
                begin
                    expected_density.push_back(column_sum[TOTAL_W-1:0]);
                    column_sum   = 0;
                    have_cell    = 1'b0;
                    counted_cell = 0;
                end
            end
            default: n_ignored++;
        endcase
        if (act != ACT_RESERVED)
            n_words++;
    endfunction

    // ---------------------------------------------------------------- driving

    task automatic send_word(input logic [ACT_W-1:0] act, input logic [POS_W-1:0] px, py, pz,
                             input logic last);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < send_idle_pct)
            gap++;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        action      <= act;
        pos_x       <= px;
        pos_y       <= py;
        pos_z       <= pz;
        last_sample <= last;
        in_valid    <= 1'b1;
        @(posedge clk);
        while (in_ready !== 1'b1)
            @(posedge clk);
        advance_mesh(act, px, py, pz, last);
    endtask

    task automatic hold_until_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_density.size() != 0)
            @(posedge clk);
    endtask

    // a closing sample flushes the block, so no deposit or clear is still running after it
    task automatic close_phase();
        send_word(ACT_SAMPLE, $urandom, $urandom, $urandom, 1'b1);
        hold_until_drained();
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_ORIGIN_X:   cfg_origin[0] = value;
            REG_ORIGIN_Y:   cfg_origin[1] = value;
            REG_ORIGIN_Z:   cfg_origin[2] = value;
            REG_CELL_SCALE: cfg_scale     = int'(value[SCALE_W-1:0]);
            REG_CELLS_X:    cfg_cells[0]  = int'(value[CNT_W-1:0]);
            REG_CELLS_Y:    cfg_cells[1]  = int'(value[CNT_W-1:0]);
            REG_CELLS_Z:    cfg_cells[2]  = int'(value[CNT_W-1:0]);
            default: ;
        endcase
    endtask

    // ---------------------------------------------------------------- stimulus helpers

    function automatic longint draw_below(input longint bound);
        return longint'({$urandom, $urandom} % $unsigned(bound));
    endfunction

    // cell width in coordinate units
    function automatic longint cell_span();
        if (cfg_scale == 0)
            return longint'(1) <<< 32;
        return (longint'(1) <<< 32) / cfg_scale;
    endfunction

    // coordinate from one cell below the mesh to one cell beyond it
    function automatic logic [POS_W-1:0] mesh_coord(input int axis);
        longint width;
        width = cell_span();
        return cfg_origin[axis] + POS_W'(draw_below(width * (cfg_cells[axis] + 2)) - width);
    endfunction

    function automatic logic [POS_W-1:0] near(input logic [POS_W-1:0] base, input longint width);
        return base + POS_W'(draw_below(2 * width) - width);
    endfunction

    // deposits around a point, then a skewer of samples walking along one axis
    task automatic run_column();
        logic [POS_W-1:0] base [3];
        logic [POS_W-1:0] pt [3];
        longint           width;
        int               n_dep;
        int               n_smp;
        int               axis;
        width = cell_span();
        for (int a = 0; a < 3; a++)
            base[a] = mesh_coord(a);
        n_dep = $urandom_range(1, 6);
        repeat (n_dep)
            send_word(ACT_DEPOSIT, near(base[0], width), near(base[1], width),
                      near(base[2], width), 1'($urandom_range(1)));
        n_smp = $urandom_range(1, 10);
        axis  = $urandom_range(2);
        pt    = base;
        for (int k = 0; k < n_smp; k++)
        begin
            if ($urandom_range(9) == 0)
                pt[axis] = $urandom;
            else if (k > 0)
                pt[axis] = pt[axis] + POS_W'(draw_below(width));
            send_word(ACT_SAMPLE, pt[0], pt[1], pt[2], k == n_smp - 1);
        end
    endtask

    task automatic apply_settings(input int phase);
        logic [POS_W-1:0] org [3];
        int               scale;
        int               cells [3];
        case (phase)
            0:
            begin
                org   = '{32'h0, 32'h0, 32'h0};
                scale = 65536;
                cells = '{16, 16, 16};
            end
            1:
            begin
                org   = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
                scale = 65536;
                cells = '{16, 16, 16};
            end
            2:
            begin
                org   = '{32'h7FFF_FFFF, 32'h8000_0000, $urandom};
                scale = 24'hFF_FFFF;
                cells = '{1, 1, 1};
            end
            3:
            begin
                org   = '{$urandom, $urandom, $urandom};
                scale = 1;
                cells = '{$urandom_range(1, 16), $urandom_range(1, 16), $urandom_range(1, 16)};
            end
            default:
            begin
                org   = '{$urandom, $urandom, $urandom};
                scale = $urandom_range(8192, 524288);
                cells = '{$urandom_range(1, 16), $urandom_range(1, 16), $urandom_range(1, 16)};
            end
        endcase
        write_register(REG_ORIGIN_X, org[0]);
        write_register(REG_ORIGIN_Y, org[1]);
        write_register(REG_ORIGIN_Z, org[2]);
        write_register(REG_CELL_SCALE, scale);
        write_register(REG_CELLS_X, cells[0]);
        write_register(REG_CELLS_Y, cells[1]);
        write_register(REG_CELLS_Z, cells[2]);
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_directed_cases();
        send_word(ACT_DEPOSIT, '0, '0, '0, 1'b0);
        send_word(ACT_DEPOSIT, 32'h0001_8000, 32'h0002_4000, 32'h0003_C000, 1'b0);
        // upper vertices fall off the far faces
        send_word(ACT_DEPOSIT, 32'h000F_8000, 32'h000F_8000, 32'h000F_8000, 1'b1);
        // lower vertices fall off the near faces
        send_word(ACT_DEPOSIT, 32'hFFFF_8000, 32'hFFFF_8000, 32'hFFFF_8000, 1'b0);
        send_word(ACT_DEPOSIT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        send_word(ACT_DEPOSIT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
        send_word(ACT_DEPOSIT, 32'h0000_4000, '0, 32'h000F_0000, 1'b0);
        send_word(ACT_SAMPLE, '0, '0, '0, 1'b0);
        send_word(ACT_SAMPLE, 32'h0000_E666, 32'h0000_1999, 32'h0000_3333, 1'b0);
        // outside point leaves the counted cell alone
        send_word(ACT_SAMPLE, 32'hFFFF_0000, '0, '0, 1'b0);
        send_word(ACT_SAMPLE, '0, '0, '0, 1'b0);
        send_word(ACT_SAMPLE, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 1'b0);
        send_word(ACT_SAMPLE, 32'h000F_0000, 32'h000F_0000, 32'h000F_0000, 1'b1);
        hold_until_drained();
        send_word(ACT_SAMPLE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
        send_word(ACT_RESERVED, '1, '1, '1, 1'b1);
        send_word(ACT_SAMPLE, '0, '0, '0, 1'b0);
        // clear wipes the mesh but keeps the open column
        send_word(ACT_CLEAR, '0, '0, '0, 1'b1);
        send_word(ACT_SAMPLE, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 1'b1);
        send_word(ACT_SAMPLE, '0, '0, '0, 1'b1);
        close_phase();
    endtask

    task automatic test_special_settings();
        // zero scale maps every point to cell zero with no fraction
        write_register(REG_CELL_SCALE, '0);
        send_word(ACT_DEPOSIT, $urandom, $urandom, $urandom, 1'b0);
        send_word(ACT_SAMPLE, $urandom, $urandom, $urandom, 1'b1);
        close_phase();
        // zero cell count leaves nothing inside
        write_register(REG_CELL_SCALE, 32'd65536);
        write_register(REG_CELLS_X, '0);
        send_word(ACT_DEPOSIT, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b0);
        send_word(ACT_SAMPLE, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b1);
        close_phase();
        // wide mesh: far cells run past the end of the store
        write_register(REG_CELLS_X, 32'd31);
        write_register(REG_CELLS_Y, 32'd31);
        write_register(REG_CELLS_Z, 32'd31);
        send_word(ACT_DEPOSIT, 32'h0014_8000, 32'h0014_8000, 32'h0014_8000, 1'b0);
        send_word(ACT_DEPOSIT, 32'h0002_8000, 32'h0003_8000, 32'h0004_8000, 1'b0);
        send_word(ACT_SAMPLE, 32'h0003_0000, 32'h0004_0000, 32'h0005_0000, 1'b0);
        send_word(ACT_SAMPLE, 32'h0014_0000, 32'h0014_0000, 32'h0014_0000, 1'b1);
        close_phase();
    endtask

    task automatic test_random_traffic();
        int               goal;
        int               pick;
        logic [ACT_W-1:0] act;
        for (int phase = 0; phase < RAND_PHASES; phase++)
        begin
            apply_settings(phase);
            case (phase % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 52; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 52; end
                default: begin send_idle_pct = 15; recv_stall_pct = 15; end
            endcase
            goal = n_words + PHASE_WORDS;
            while (n_words < goal)
            begin
                if ($urandom_range(19) == 0)
                    hold_until_drained();
                pick = $urandom_range(99);
                if (pick < 75)
                    run_column();
                else if (pick < 87)
                begin
                    act = $urandom_range(1) ? ACT_SAMPLE : ACT_DEPOSIT;
                    send_word(act, mesh_coord(0), mesh_coord(1), mesh_coord(2),
                              1'($urandom_range(1)));
                end
                else if (pick < 97)
                begin
                    case ($urandom_range(2))
                        0:       act = ACT_DEPOSIT;
                        1:       act = ACT_SAMPLE;
                        default: act = ACT_RESERVED;
                    endcase
                    send_word(act, $urandom, $urandom, $urandom, 1'($urandom_range(1)));
                end
                else
                    send_word(ACT_CLEAR, $urandom, $urandom, $urandom, 1'($urandom_range(1)));
            end
            close_phase();
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        cfg_write   = 1'b0;
        cfg_index   = REG_ORIGIN_X;
        cfg_data    = '0;
        in_valid    = 1'b0;
        action      = ACT_DEPOSIT;
        pos_x       = '0;
        pos_y       = '0;
        pos_z       = '0;
        last_sample = 1'b0;

        cfg_origin   = '{32'h0, 32'h0, 32'h0};
        cfg_scale    = 1 << FRAC_BITS;
        cfg_cells    = '{16, 16, 16};
        column_sum   = 0;
        have_cell    = 1'b0;
        counted_cell = 0;
        foreach (mesh_weight[i])
            mesh_weight[i] = '0;

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_special_settings();
        test_random_traffic();

        $display("Covered %0d deposits, %0d samples, %0d clears, %0d reserved words over %0d settings",
                 n_deposit, n_sample, n_clear, n_ignored, RAND_PHASES + 4);
        $display("Checked %0d column results, %0d mismatches", results_checked, errors);
        if (errors == 0)
            $display("cloud_in_cell_density_mesh test passed");
        else
            $display("cloud_in_cell_density_mesh test failed");
        $finish;
    end

endmodule

[files.f]
rtl/cicdm_pkg.sv
rtl/cloud_in_cell_density_mesh.sv
sim/tb_cloud_in_cell_density_mesh.sv
